// ===== rtl/tprs_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-plate release sequencer package
// Shared types, codes and constants for the sequencer datapath and registers.
// ----------------------------------------------------------------------------
package tprs_pkg;

   // field widths fixed by the interface
   localparam int CFG_BITS          = 24;
   localparam int STEP_TOTAL_BITS   = 32;
   localparam int PHASE_BITS        = 4;
   localparam int EVENT_BITS        = 3;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int STEP_BITS_DEFAULT = 32;

   // command codes
   localparam logic OP_POLL  = 1'b0;
   localparam logic OP_START = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_STEPS   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLAG_REOPEN    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_TARGET = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FINAL_RUN      = 2'd3;

   // event codes
   localparam logic [EVENT_BITS-1:0] EV_NONE     = 3'd0;
   localparam logic [EVENT_BITS-1:0] EV_STARTED  = 3'd1;
   localparam logic [EVENT_BITS-1:0] EV_REJECTED = 3'd2;
   localparam logic [EVENT_BITS-1:0] EV_COMPLETE = 3'd3;
   localparam logic [EVENT_BITS-1:0] EV_ABORTED  = 3'd4;

   // phase codes as reported on the result channel
   localparam logic [PHASE_BITS-1:0] PHC_IDLE    = 4'd0;
   localparam logic [PHASE_BITS-1:0] PHC_SEEK1   = 4'd1;
   localparam logic [PHASE_BITS-1:0] PHC_CENTER1 = 4'd2;
   localparam logic [PHASE_BITS-1:0] PHC_TRACK1  = 4'd3;
   localparam logic [PHASE_BITS-1:0] PHC_SEEK2   = 4'd4;
   localparam logic [PHASE_BITS-1:0] PHC_CENTER2 = 4'd5;
   localparam logic [PHASE_BITS-1:0] PHC_WAIT    = 4'd6;
   localparam logic [PHASE_BITS-1:0] PHC_AFTER   = 4'd7;
   localparam logic [PHASE_BITS-1:0] PHC_LEAVE2  = 4'd8;
   localparam logic [PHASE_BITS-1:0] PHC_FINAL   = 4'd9;

   // sequencer phase, one-hot
   typedef enum logic [9:0] {
      PH_IDLE    = 10'b00_0000_0001,
      PH_SEEK1   = 10'b00_0000_0010,
      PH_CENTER1 = 10'b00_0000_0100,
      PH_TRACK1  = 10'b00_0000_1000,
      PH_SEEK2   = 10'b00_0001_0000,
      PH_CENTER2 = 10'b00_0010_0000,
      PH_WAIT    = 10'b00_0100_0000,
      PH_AFTER   = 10'b00_1000_0000,
      PH_LEAVE2  = 10'b01_0000_0000,
      PH_FINAL   = 10'b10_0000_0000
   } phase_type;

   // configuration registers as seen by the sequencer
   typedef struct packed {
      logic [CFG_BITS-1:0] center_steps;
      logic [CFG_BITS-1:0] flag_reopen_steps;
      logic [CFG_BITS-1:0] release_target_steps;
      logic [CFG_BITS-1:0] final_run_steps;
   } cfg_type;

   // one input transaction
   typedef struct packed {
      logic                       op;
      logic [STEP_TOTAL_BITS-1:0] step_total;
      logic                       plate_present;
      logic                       motion_running;
   } req_item_type;

   // one result transaction
   typedef struct packed {
      logic                  flag_lowered;
      logic                  start_motion;
      logic                  arm_stop;
      logic [CFG_BITS-1:0]   stop_after;
      logic                  cycle_active;
      logic [PHASE_BITS-1:0] phase;
      logic [EVENT_BITS-1:0] event_res;
   } rsp_item_type;

   // map the one-hot phase to its reported code
   function automatic logic [PHASE_BITS-1:0] phase_code(input phase_type ph);
      logic [PHASE_BITS-1:0] code;
      case (ph)
         PH_IDLE:    code = PHC_IDLE;
         PH_SEEK1:   code = PHC_SEEK1;
         PH_CENTER1: code = PHC_CENTER1;
         PH_TRACK1:  code = PHC_TRACK1;
         PH_SEEK2:   code = PHC_SEEK2;
         PH_CENTER2: code = PHC_CENTER2;
         PH_WAIT:    code = PHC_WAIT;
         PH_AFTER:   code = PHC_AFTER;
         PH_LEAVE2:  code = PHC_LEAVE2;
         PH_FINAL:   code = PHC_FINAL;
         default:    code = PHC_IDLE;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/tprs_csr.sv =====
// ----------------------------------------------------------------------------
// Two-plate release sequencer configuration registers
// Holds the four step-count registers written through the csr channel.
// ----------------------------------------------------------------------------
module tprs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [tprs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tprs_pkg::CFG_BITS-1:0]       csr_data,
   output tprs_pkg::cfg_type                    cfg
);

   tprs_pkg::cfg_type cfg_ff;
   tprs_pkg::cfg_type cfg_in;

   // decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tprs_pkg::CSR_CENTER_STEPS:   cfg_in.center_steps         = csr_data;
            tprs_pkg::CSR_FLAG_REOPEN:    cfg_in.flag_reopen_steps    = csr_data;
            tprs_pkg::CSR_RELEASE_TARGET: cfg_in.release_target_steps = csr_data;
            tprs_pkg::CSR_FINAL_RUN:      cfg_in.final_run_steps      = csr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/tprs_seq.sv =====
// ----------------------------------------------------------------------------
// Two-plate release sequencer phase logic
// Holds the phase and step marks and computes one result per transaction.
// ----------------------------------------------------------------------------
module tprs_seq #(
   parameter int STEP_BITS = tprs_pkg::STEP_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  tprs_pkg::req_item_type item,
   input  tprs_pkg::cfg_type      cfg,
   output tprs_pkg::rsp_item_type result
);

   localparam int CFG_BITS = tprs_pkg::CFG_BITS;
   localparam int CMP_BITS = (STEP_BITS > CFG_BITS) ? STEP_BITS : CFG_BITS;

   // distance against a register limit, both zero-extended
   function automatic logic at_least(input logic [STEP_BITS-1:0] span,
                                     input logic [CFG_BITS-1:0]  lim);
      return CMP_BITS'(span) >= CMP_BITS'(lim);
   endfunction

   // control state
   tprs_pkg::phase_type phase_ff, phase_in;
   logic                flag_ff, flag_in;
   logic                first_left_ff, first_left_in;
   logic                second_left_ff, second_left_in;

   // step marks and latched values
   logic [STEP_BITS-1:0] center_mark_ff, center_mark_in;
   logic [STEP_BITS-1:0] drop1_mark_ff, drop1_mark_in;
   logic [STEP_BITS-1:0] leave1_mark_ff, leave1_mark_in;
   logic [STEP_BITS-1:0] drop2_mark_ff, drop2_mark_in;
   logic [CFG_BITS-1:0]  window_ff, window_in;
   logic [CFG_BITS-1:0]  center_lat_ff, center_lat_in;

   logic [STEP_BITS-1:0] now;
   logic [STEP_BITS-1:0] since_center, since_drop1, since_drop2, since_leave;
   logic [CMP_BITS-1:0]  transit_ext, target_ext, window_diff;
   logic [CFG_BITS-1:0]  window_cap;
   logic                 cap_first, cap_second, first_left_eff, second_left_eff;
   logic                 leave_ok, running;
   logic                 start_motion, arm_stop;
   logic [CFG_BITS-1:0]  stop_after;
   logic [tprs_pkg::EVENT_BITS-1:0] event_res;

   // wrapping distances from each mark
   assign now          = STEP_BITS'(item.step_total);
   assign since_center = now - center_mark_ff;
   assign since_drop1  = now - drop1_mark_ff;
   assign since_drop2  = now - drop2_mark_ff;
   assign since_leave  = now - leave1_mark_ff;
   assign running      = (phase_ff != tprs_pkg::PH_IDLE);

   // first plate leaving: capture its transit and the release window
   assign cap_first      = !first_left_ff && !item.plate_present;
   assign first_left_eff = first_left_ff || cap_first;
   assign transit_ext    = CMP_BITS'(since_drop1);
   assign target_ext     = CMP_BITS'(cfg.release_target_steps);
   assign window_diff    = target_ext - transit_ext;
   assign window_cap     = (transit_ext < target_ext) ? window_diff[CFG_BITS-1:0] : '0;
   assign leave_ok       = cap_first ? (window_cap == '0)
                                     : at_least(since_leave, window_ff);

   // second plate leaving
   assign cap_second      = !second_left_ff && !item.plate_present;
   assign second_left_eff = second_left_ff || cap_second;

   // next state and result
   always_comb begin
      phase_in       = phase_ff;
      flag_in        = flag_ff;
      first_left_in  = first_left_ff;
      second_left_in = second_left_ff;
      center_mark_in = center_mark_ff;
      drop1_mark_in  = drop1_mark_ff;
      leave1_mark_in = leave1_mark_ff;
      drop2_mark_in  = drop2_mark_ff;
      window_in      = window_ff;
      center_lat_in  = center_lat_ff;
      start_motion   = 1'b0;
      arm_stop       = 1'b0;
      stop_after     = '0;
      event_res      = tprs_pkg::EV_NONE;

      if (item.op == tprs_pkg::OP_START) begin
         if (item.motion_running || running) begin
            event_res = tprs_pkg::EV_REJECTED;
         end else begin
            flag_in        = 1'b0;
            start_motion   = 1'b1;
            phase_in       = item.plate_present ? tprs_pkg::PH_CENTER1 : tprs_pkg::PH_SEEK1;
            first_left_in  = 1'b0;
            second_left_in = 1'b0;
            center_mark_in = now;
            center_lat_in  = cfg.center_steps;
            drop1_mark_in  = now;
            leave1_mark_in = now;
            drop2_mark_in  = now;
            window_in      = '0;
            event_res      = tprs_pkg::EV_STARTED;
         end
      end else if (running) begin
         if (!item.motion_running) begin
            // motion ended: complete in the final phase, abort elsewhere
            event_res = (phase_ff == tprs_pkg::PH_FINAL) ? tprs_pkg::EV_COMPLETE
                                                         : tprs_pkg::EV_ABORTED;
            phase_in  = tprs_pkg::PH_IDLE;
         end else begin
            // capture the first leave in the phases that watch for it
            if (cap_first && (phase_ff == tprs_pkg::PH_TRACK1 ||
                              phase_ff == tprs_pkg::PH_SEEK2  ||
                              phase_ff == tprs_pkg::PH_CENTER2 ||
                              phase_ff == tprs_pkg::PH_WAIT)) begin
               first_left_in  = 1'b1;
               leave1_mark_in = now;
               window_in      = window_cap;
            end
            // capture the second leave
            if (phase_ff == tprs_pkg::PH_AFTER || phase_ff == tprs_pkg::PH_LEAVE2) begin
               second_left_in = second_left_eff;
            end
            case (phase_ff)
               tprs_pkg::PH_SEEK1: begin
                  if (item.plate_present) begin
                     center_mark_in = now;
                     phase_in       = tprs_pkg::PH_CENTER1;
                  end
               end
               tprs_pkg::PH_CENTER1: begin
                  if (at_least(since_center, center_lat_ff)) begin
                     flag_in       = 1'b1;
                     drop1_mark_in = now;
                     first_left_in = 1'b0;
                     phase_in      = tprs_pkg::PH_TRACK1;
                  end
               end
               tprs_pkg::PH_TRACK1: begin
                  if (at_least(since_drop1, cfg.flag_reopen_steps)) begin
                     flag_in  = 1'b0;
                     phase_in = tprs_pkg::PH_SEEK2;
                  end
               end
               tprs_pkg::PH_SEEK2: begin
                  if (item.plate_present) begin
                     center_mark_in = now;
                     phase_in       = tprs_pkg::PH_CENTER2;
                  end
               end
               tprs_pkg::PH_CENTER2: begin
                  if (at_least(since_center, center_lat_ff)) begin
                     phase_in = tprs_pkg::PH_WAIT;
                  end
               end
               tprs_pkg::PH_WAIT: begin
                  if (first_left_eff && leave_ok) begin
                     flag_in        = 1'b1;
                     drop2_mark_in  = now;
                     second_left_in = 1'b0;
                     phase_in       = tprs_pkg::PH_AFTER;
                  end
               end
               tprs_pkg::PH_AFTER: begin
                  if (at_least(since_drop2, cfg.flag_reopen_steps)) begin
                     flag_in = 1'b0;
                     if (second_left_eff) begin
                        arm_stop   = 1'b1;
                        stop_after = cfg.final_run_steps;
                        phase_in   = tprs_pkg::PH_FINAL;
                     end else begin
                        phase_in = tprs_pkg::PH_LEAVE2;
                     end
                  end
               end
               tprs_pkg::PH_LEAVE2: begin
                  if (second_left_eff) begin
                     arm_stop   = 1'b1;
                     stop_after = cfg.final_run_steps;
                     phase_in   = tprs_pkg::PH_FINAL;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // hold state between transactions, update on each one
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= tprs_pkg::PH_IDLE;
         flag_ff        <= 1'b0;
         first_left_ff  <= 1'b0;
         second_left_ff <= 1'b0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         flag_ff        <= flag_in;
         first_left_ff  <= first_left_in;
         second_left_ff <= second_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         center_mark_ff <= center_mark_in;
         drop1_mark_ff  <= drop1_mark_in;
         leave1_mark_ff <= leave1_mark_in;
         drop2_mark_ff  <= drop2_mark_in;
         window_ff      <= window_in;
         center_lat_ff  <= center_lat_in;
      end
   end

   // assemble the result transaction
   always_comb begin
      result.flag_lowered = flag_in;
      result.start_motion = start_motion;
      result.arm_stop     = arm_stop;
      result.stop_after   = stop_after;
      result.cycle_active = (phase_in != tprs_pkg::PH_IDLE);
      result.phase        = tprs_pkg::phase_code(phase_in);
      result.event_res    = event_res;
   end

endmodule

// ===== rtl/two_plate_release_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// Two-plate release sequencer
// Steps a conveyor through seek, center, flag drop and reopen for two plates.
// ----------------------------------------------------------------------------
// Each transaction on req_ is a start command or a poll and yields exactly one
// result on rsp_. The block takes one transaction per clock: the request is
// held in an input register, the phase logic evaluates it there once the
// output register is free, and the result lands in the output register,
// from which it is presented on rsp_ until taken.
// When rsp_ready is low the output register holds,
// the input register fills behind it and req_ready drops; throughput returns
// to one per clock as soon as rsp_ready is high again. Configuration writes
// are taken every cycle and apply at once, except center_steps, which is
// sampled when a cycle starts. All step distances wrap at STEP_BITS bits.
module two_plate_release_sequencer_unit #(
   parameter int STEP_BITS = tprs_pkg::STEP_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic [tprs_pkg::STEP_TOTAL_BITS-1:0]  req_step_total,
   input  logic                                  req_plate_present,
   input  logic                                  req_motion_running,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_flag_lowered,
   output logic                                  rsp_start_motion,
   output logic                                  rsp_arm_stop,
   output logic [tprs_pkg::CFG_BITS-1:0]         rsp_stop_after,
   output logic                                  rsp_cycle_active,
   output logic [tprs_pkg::PHASE_BITS-1:0]       rsp_phase,
   output logic [tprs_pkg::EVENT_BITS-1:0]       rsp_event_res,
   // configuration channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tprs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tprs_pkg::CFG_BITS-1:0]         csr_data
);

   tprs_pkg::cfg_type      cfg;
   tprs_pkg::req_item_type req_item_ff, req_item_in;
   tprs_pkg::rsp_item_type rsp_item_ff, step_result;
   logic                   in_valid_ff, in_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_free, advance, req_take;

   assign csr_ready = 1'b1;

   tprs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // handshake: output register frees when empty or drained
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // capture the request transaction
   always_comb begin
      req_item_in                = req_item_ff;
      if (req_take) begin
         req_item_in.op             = req_op;
         req_item_in.step_total     = req_step_total;
         req_item_in.plate_present  = req_plate_present;
         req_item_in.motion_running = req_motion_running;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   tprs_seq #(
      .STEP_BITS (STEP_BITS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // drive the response channel
   assign rsp_valid        = out_valid_ff;
   assign rsp_flag_lowered = rsp_item_ff.flag_lowered;
   assign rsp_start_motion = rsp_item_ff.start_motion;
   assign rsp_arm_stop     = rsp_item_ff.arm_stop;
   assign rsp_stop_after   = rsp_item_ff.stop_after;
   assign rsp_cycle_active = rsp_item_ff.cycle_active;
   assign rsp_phase        = rsp_item_ff.phase;
   assign rsp_event_res    = rsp_item_ff.event_res;

   // a stop is armed only on entry to the final phase
   a_arm_final : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arm_stop |-> rsp_phase == tprs_pkg::PHC_FINAL)
      else $error("arm_stop outside final phase");

   // a motion start comes only with a started event and an active cycle
   a_start_event : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_motion |->
         rsp_event_res == tprs_pkg::EV_STARTED && rsp_cycle_active)
      else $error("start_motion without started event");

   // completion and abort leave the sequencer idle
   a_end_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == tprs_pkg::EV_COMPLETE ||
                    rsp_event_res == tprs_pkg::EV_ABORTED) |->
         !rsp_cycle_active && rsp_phase == tprs_pkg::PHC_IDLE)
      else $error("cycle end did not return to idle");

   // the active flag agrees with the reported phase
   a_active_phase : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cycle_active == (rsp_phase != tprs_pkg::PHC_IDLE))
      else $error("cycle_active disagrees with phase");

endmodule

// ===== sim/two_plate_release_sequencer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-plate release sequencer testbench
// Drives start and poll transactions into the sequencer and checks every
// result against an internal model. The model keeps its own phase, marks and
// register copies. A short directed part covers the corner cases. Random
// plate sequences follow, with sensor noise, mid-cycle motion loss and stray
// starts. Register settings change between runs and include all zeros and
// all ones.
// ----------------------------------------------------------------------------
module two_plate_release_sequencer_unit_test;
   import tprs_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid          = 1'b0;
   logic                       req_ready;
   logic                       req_op             = OP_POLL;
   logic [STEP_TOTAL_BITS-1:0] req_step_total     = '0;
   logic                       req_plate_present  = 1'b0;
   logic                       req_motion_running = 1'b0;

   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_flag_lowered;
   logic                       rsp_start_motion;
   logic                       rsp_arm_stop;
   logic [CFG_BITS-1:0]        rsp_stop_after;
   logic                       rsp_cycle_active;
   logic [PHASE_BITS-1:0]      rsp_phase;
   logic [EVENT_BITS-1:0]      rsp_event_res;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = CSR_CENTER_STEPS;
   logic [CFG_BITS-1:0]        csr_data  = '0;

   // model state: registers, sequencer phase and step marks
   cfg_type                    cfg;
   logic                       seq_running;
   logic [PHASE_BITS-1:0]      seq_phase;
   logic                       first_gone;
   logic                       second_gone;
   logic                       flag_down;
   logic [CFG_BITS-1:0]        center_latch;
   logic [STEP_TOTAL_BITS-1:0] center_mark;
   logic [STEP_TOTAL_BITS-1:0] first_drop_mark;
   logic [STEP_TOTAL_BITS-1:0] first_leave_mark;
   logic [STEP_TOTAL_BITS-1:0] second_drop_mark;
   logic [STEP_TOTAL_BITS-1:0] release_window;

   rsp_item_type               expected_results[$];
   rsp_item_type               wanted;
   req_item_type               accepted;
   int                         error_count = 0;
   int                         cycle_count = 0;
   int                         stall_left  = 0;
   bit                         sender_gaps     = 1'b1;
   bit                         receiver_stalls = 1'b1;

   two_plate_release_sequencer_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_step_total     (req_step_total),
      .req_plate_present  (req_plate_present),
      .req_motion_running (req_motion_running),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_flag_lowered   (rsp_flag_lowered),
      .rsp_start_motion   (rsp_start_motion),
      .rsp_arm_stop       (rsp_arm_stop),
      .rsp_stop_after     (rsp_stop_after),
      .rsp_cycle_active   (rsp_cycle_active),
      .rsp_phase          (rsp_phase),
      .rsp_event_res      (rsp_event_res),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Sequencer model
   // ------------------------------------------------------------------------

   function automatic logic [STEP_TOTAL_BITS-1:0] steps_since(
      input logic [STEP_TOTAL_BITS-1:0] now,
      input logic [STEP_TOTAL_BITS-1:0] mark
   );
      return now - mark;
   endfunction

   // latch the first plate's exit and derive the release window, floored at zero
   function automatic void note_first_leave(input logic [STEP_TOTAL_BITS-1:0] now,
                                            input logic plate);
      logic [STEP_TOTAL_BITS-1:0] transit;
      if (first_gone || plate) return;
      first_gone       = 1'b1;
      first_leave_mark = now;
      transit          = steps_since(now, first_drop_mark);
      if (transit < cfg.release_target_steps)
         release_window = cfg.release_target_steps - transit;
      else
         release_window = '0;
   endfunction

   function automatic void clear_sequencer();
      cfg              = '0;
      seq_running      = 1'b0;
      seq_phase        = PHC_IDLE;
      first_gone       = 1'b0;
      second_gone      = 1'b0;
      flag_down        = 1'b0;
      center_latch     = '0;
      center_mark      = '0;
      first_drop_mark  = '0;
      first_leave_mark = '0;
      second_drop_mark = '0;
      release_window   = '0;
   endfunction

   // advance the model by one transaction and return the result it implies
   function automatic rsp_item_type sequence_step(input req_item_type item);
      rsp_item_type               res;
      logic [STEP_TOTAL_BITS-1:0] now;
      res = '0;
      now = item.step_total;
      if (item.op == OP_START) begin
         if (item.motion_running || seq_running) begin
            res.event_res = EV_REJECTED;
         end else begin
            flag_down        = 1'b0;
            res.start_motion = 1'b1;
            seq_running      = 1'b1;
            seq_phase        = item.plate_present ? PHC_CENTER1 : PHC_SEEK1;
            first_gone       = 1'b0;
            second_gone      = 1'b0;
            center_mark      = now;
            center_latch     = cfg.center_steps;
            first_drop_mark  = now;
            first_leave_mark = now;
            second_drop_mark = now;
            release_window   = '0;
            res.event_res    = EV_STARTED;
         end
      end else if (seq_running && seq_phase != PHC_IDLE) begin
         if (!item.motion_running) begin
            res.event_res = (seq_phase == PHC_FINAL) ? EV_COMPLETE : EV_ABORTED;
            seq_running   = 1'b0;
            seq_phase     = PHC_IDLE;
         end else begin
            case (seq_phase)
               PHC_SEEK1: begin
                  if (item.plate_present) begin
                     center_mark = now;
                     seq_phase   = PHC_CENTER1;
                  end
               end
               PHC_CENTER1: begin
                  if (steps_since(now, center_mark) >= center_latch) begin
                     flag_down       = 1'b1;
                     first_drop_mark = now;
                     first_gone      = 1'b0;
                     seq_phase       = PHC_TRACK1;
                  end
               end
               PHC_TRACK1: begin
                  note_first_leave(now, item.plate_present);
                  if (steps_since(now, first_drop_mark) >= cfg.flag_reopen_steps) begin
                     flag_down = 1'b0;
                     seq_phase = PHC_SEEK2;
                  end
               end
               PHC_SEEK2: begin
                  note_first_leave(now, item.plate_present);
                  if (item.plate_present) begin
                     center_mark = now;
                     seq_phase   = PHC_CENTER2;
                  end
               end
               PHC_CENTER2: begin
                  note_first_leave(now, item.plate_present);
                  if (steps_since(now, center_mark) >= center_latch)
                     seq_phase = PHC_WAIT;
               end
               PHC_WAIT: begin
                  note_first_leave(now, item.plate_present);
                  if (first_gone &&
                      steps_since(now, first_leave_mark) >= release_window) begin
                     flag_down        = 1'b1;
                     second_drop_mark = now;
                     second_gone      = 1'b0;
                     seq_phase        = PHC_AFTER;
                  end
               end
               PHC_AFTER: begin
                  if (!item.plate_present) second_gone = 1'b1;
                  if (steps_since(now, second_drop_mark) >= cfg.flag_reopen_steps) begin
                     flag_down = 1'b0;
                     if (second_gone) begin
                        res.arm_stop   = 1'b1;
                        res.stop_after = cfg.final_run_steps;
                        seq_phase      = PHC_FINAL;
                     end else begin
                        seq_phase = PHC_LEAVE2;
                     end
                  end
               end
               PHC_LEAVE2: begin
                  if (!item.plate_present) begin
                     second_gone    = 1'b1;
                     res.arm_stop   = 1'b1;
                     res.stop_after = cfg.final_run_steps;
                     seq_phase      = PHC_FINAL;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      res.flag_lowered = flag_down;
      res.cycle_active = seq_running;
      res.phase        = seq_phase;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: check results, predict accepted requests, track register writes
   // ------------------------------------------------------------------------

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else if (reset) begin
         clear_sequencer();
      end else begin
         // check before predicting so a stray result never meets a fresh entry
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with no expected result pending");
               error_count++;
            end else begin
               wanted = expected_results.pop_front();
               compare_field("flag_lowered", 32'(wanted.flag_lowered),
                             32'(rsp_flag_lowered));
               compare_field("start_motion", 32'(wanted.start_motion),
                             32'(rsp_start_motion));
               compare_field("arm_stop", 32'(wanted.arm_stop), 32'(rsp_arm_stop));
               compare_field("stop_after", 32'(wanted.stop_after), 32'(rsp_stop_after));
               compare_field("cycle_active", 32'(wanted.cycle_active),
                             32'(rsp_cycle_active));
               compare_field("phase", 32'(wanted.phase), 32'(rsp_phase));
               compare_field("event_res", 32'(wanted.event_res), 32'(rsp_event_res));
            end
         end
         if (req_valid && req_ready) begin
            accepted.op             = req_op;
            accepted.step_total     = req_step_total;
            accepted.plate_present  = req_plate_present;
            accepted.motion_running = req_motion_running;
            expected_results.push_back(sequence_step(accepted));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTER_STEPS:   cfg.center_steps         = csr_data;
               CSR_FLAG_REOPEN:    cfg.flag_reopen_steps    = csr_data;
               CSR_RELEASE_TARGET: cfg.release_target_steps = csr_data;
               CSR_FINAL_RUN:      cfg.final_run_steps      = csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // hold off the result channel in short random bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // present one request, optionally after a short gap, and hold until taken
   task automatic send_item(input logic op, input logic [STEP_TOTAL_BITS-1:0] steps,
                            input logic plate, input logic motion);
      int gap;
      gap = (sender_gaps && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_step_total     <= steps;
      req_plate_present  <= plate;
      req_motion_running <= motion;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop the request valid and wait for every pending result
   task automatic drain_results();
      @(negedge clock) req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CFG_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // write all four registers once the request side is quiet
   task automatic write_config(input logic [CFG_BITS-1:0] center,
                               input logic [CFG_BITS-1:0] reopen,
                               input logic [CFG_BITS-1:0] target,
                               input logic [CFG_BITS-1:0] final_run);
      drain_results();
      write_register(CSR_CENTER_STEPS, center);
      write_register(CSR_FLAG_REOPEN, reopen);
      write_register(CSR_RELEASE_TARGET, target);
      write_register(CSR_FINAL_RUN, final_run);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // polls while idle and a start refused because motion is already running
   task automatic test_idle_requests();
      send_item(OP_POLL, 32'h0000_0000, 1'b0, 1'b0);
      send_item(OP_POLL, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_item(OP_START, 32'h1234_5678, 1'b0, 1'b1);
   endtask

   // full two-plate cycle across the step counter wrap, ending in completion
   task automatic test_wrapping_cycle();
      write_config(24'd4, 24'd3, 24'd40, 24'hFF_FFFF);
      send_item(OP_START, 32'hFFFF_FFF0, 1'b0, 1'b0);
      send_item(OP_POLL, 32'hFFFF_FFF2, 1'b0, 1'b1);
      send_item(OP_POLL, 32'hFFFF_FFF4, 1'b1, 1'b1);
      send_item(OP_POLL, 32'hFFFF_FFFA, 1'b1, 1'b1);
      // start during a running cycle is refused
      send_item(OP_START, 32'hFFFF_FFFB, 1'b1, 1'b0);
      send_item(OP_POLL, 32'hFFFF_FFFE, 1'b0, 1'b1);
      send_item(OP_POLL, 32'h0000_0002, 1'b1, 1'b1);
      // centering keeps the value latched at start
      write_config(24'hFF_FFFF, 24'd3, 24'd40, 24'hFF_FFFF);
      send_item(OP_POLL, 32'h0000_0006, 1'b1, 1'b1);
      send_item(OP_POLL, 32'h0000_0010, 1'b0, 1'b1);
      send_item(OP_POLL, 32'h0000_0022, 1'b0, 1'b1);
      send_item(OP_POLL, 32'h0000_0023, 1'b0, 1'b1);
      send_item(OP_POLL, 32'h0000_0025, 1'b0, 1'b1);
      send_item(OP_POLL, 32'h0000_0030, 1'b1, 1'b1);
      send_item(OP_POLL, 32'h0000_0031, 1'b0, 1'b0);
   endtask

   // zero settings: start on a present plate, window floored, abort mid-cycle
   task automatic test_abort_zero_window();
      write_config(24'd0, 24'd0, 24'd0, 24'd0);
      send_item(OP_START, 32'h0000_0000, 1'b1, 1'b0);
      send_item(OP_POLL, 32'h0000_0000, 1'b1, 1'b1);
      send_item(OP_POLL, 32'h0000_0001, 1'b0, 1'b1);
      send_item(OP_POLL, 32'h0000_0002, 1'b1, 1'b1);
      send_item(OP_POLL, 32'h0000_0003, 1'b1, 1'b1);
      send_item(OP_POLL, 32'h0000_0004, 1'b0, 1'b1);
      send_item(OP_POLL, 32'h8000_0000, 1'b0, 1'b0);
      send_item(OP_START, 32'h8000_0001, 1'b0, 1'b0);
   endtask

   // random plate sequences with noise, stray starts and early motion loss
   task automatic test_random_sequences(input int item_goal, input bit allow_idle);
      int                         sent;
      int                         seg;
      int                         count;
      int                         cut_seg;
      logic                       plate;
      logic [STEP_TOTAL_BITS-1:0] steps;
      sent = 0;
      while (sent < item_goal) begin
         sender_gaps     = allow_idle && ($urandom_range(0, 3) != 0);
         receiver_stalls = allow_idle && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 6) == 0) begin
            // unstructured noise
            count = $urandom_range(1, 6);
            repeat (count) begin
               send_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
               sent++;
            end
         end else begin
            steps   = $urandom;
            cut_seg = $urandom_range(0, 14);
            send_item(OP_START, steps, $urandom_range(0, 3) == 0, 1'b0);
            sent++;
            // sensor pattern: gap, plate one, gap, plate two, run out
            for (seg = 0; seg < 5 && seg <= cut_seg; seg++) begin
               if (seg == 4)      count = $urandom_range(4, 30);
               else if (seg == 0) count = $urandom_range(0, 4);
               else               count = $urandom_range(1, 8);
               repeat (count) begin
                  if ($urandom_range(0, 39) == 0) steps = steps + $urandom;
                  else                            steps = steps + $urandom_range(0, 6);
                  plate = seg[0] ^ ($urandom_range(0, 19) == 0);
                  if ($urandom_range(0, 49) == 0)
                     send_item(OP_START, steps, plate, 1'($urandom_range(0, 1)));
                  else
                     send_item(OP_POLL, steps, plate, 1'b1);
                  sent++;
               end
            end
            // motion ends: completion from the final phase, abort elsewhere
            send_item(OP_POLL, steps + $urandom_range(0, 6), 1'($urandom_range(0, 1)),
                      1'b0);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_idle_requests();
      test_wrapping_cycle();
      test_abort_zero_window();

      write_config(24'($urandom_range(0, 12)), 24'($urandom_range(0, 12)),
                   24'($urandom_range(0, 60)), 24'($urandom));
      test_random_sequences(250, 1'b1);
      write_config(24'd0, 24'd0, 24'd0, 24'd0);
      test_random_sequences(150, 1'b1);
      write_config(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
      test_random_sequences(100, 1'b1);
      write_config(24'($urandom_range(0, 12)), 24'($urandom_range(0, 12)),
                   24'($urandom_range(0, 60)), 24'($urandom));
      test_random_sequences(250, 1'b1);
      // last stretch runs at full rate on both sides
      write_config(24'($urandom_range(0, 12)), 24'($urandom_range(0, 12)),
                   24'($urandom_range(0, 60)), 24'($urandom));
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      test_random_sequences(250, 1'b0);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
